// ===== rtl/hrhc_pkg.sv =====
// Shared types and constants for the heater ramp controller.
// Holds field widths, register indexes, reset values, mode codes and structs.
// No dependencies.
package hrhc_pkg;

  // Field widths fixed by the stream and register layouts.
  localparam int TEMP_W     = 13;
  localparam int DUTY_W     = 10;
  localparam int TARGET_W   = 5;
  localparam int BAND_W     = 4;
  localparam int STEP_W     = 3;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 14;
  localparam int PROD_W     = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 8'd1;

  // Reset values.
  localparam logic [TARGET_W-1:0] TARGET_RST = 5'd25;
  localparam logic [BAND_W-1:0]   BAND_RST   = 4'd2;
  localparam logic [STEP_W-1:0]   FALL_RST   = 3'd4;

  // Largest duty the output can carry.
  localparam logic [DUTY_W-1:0]   DUTY_SAT   = 10'd1023;

  // Mode codes as seen on the result stream.
  localparam logic [MODE_W-1:0] CODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] CODE_RISE = 2'd1;
  localparam logic [MODE_W-1:0] CODE_HOLD = 2'd2;
  localparam logic [MODE_W-1:0] CODE_FALL = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_RISE = 4'b0010,
    MODE_HOLD = 4'b0100,
    MODE_FALL = 4'b1000
  } mode_t;

  // Switching thresholds in sample units.
  typedef struct packed {
    logic signed [THR_W-1:0] on_th;
    logic signed [THR_W-1:0] off_th;
  } thresh_t;

  // One result beat before packing.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              heat;
    logic [MODE_W-1:0] mode;
  } result_t;

  // Map a one-hot state onto its output code.
  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_IDLE: c = CODE_IDLE;
      MODE_RISE: c = CODE_RISE;
      MODE_HOLD: c = CODE_HOLD;
      MODE_FALL: c = CODE_FALL;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hrhc_cfg.sv =====
// Configuration registers of the heater ramp controller and threshold math.
// Depends on hrhc_pkg.
module hrhc_cfg
  import hrhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output thresh_t               thr
);

  logic [TARGET_W-1:0] target_temp;
  logic [BAND_W-1:0]   band_width;
  logic signed [6:0]   diff;
  logic [6:0]          sum;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= TARGET_RST;
      band_width  <= BAND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET: target_temp <= cfg_data[TARGET_W-1:0];
        REG_BAND:   band_width  <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds are (target -/+ band) scaled by 16 to sample units.
  always_comb begin
    diff       = $signed({2'b00, target_temp}) - $signed({3'b000, band_width});
    sum        = {2'b00, target_temp} + {3'b000, band_width};
    thr.on_th  = $signed({{3{diff[6]}}, diff, 4'b0000});
    thr.off_th = $signed({3'b000, sum, 4'b0000});
  end

endmodule

// ===== rtl/hrhc_ctrl.sv =====
// Mode sequencer of the heater ramp controller: state registers and step logic.
// Depends on hrhc_pkg; thresholds come from hrhc_cfg.
module hrhc_ctrl
  import hrhc_pkg::*;
#(
  parameter int RAMP_STEPS = 4,
  parameter int DUTY_STEP  = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic signed [TEMP_W-1:0] sample,
  input  thresh_t                  thr,
  output result_t                  res
);

  localparam logic [STEP_W-1:0] RAMP = STEP_W'(RAMP_STEPS);
  localparam logic [PROD_W-1:0] STEP = PROD_W'(DUTY_STEP);

  mode_t             mode, mode_next;
  logic [STEP_W-1:0] rise_step, rise_step_next;
  logic [STEP_W-1:0] fall_step, fall_step_next;
  logic [DUTY_W-1:0] duty, duty_next;
  logic              heat, heat_next;
  logic signed [THR_W-1:0] t;
  logic              below_on, below_off, above_off;
  logic [STEP_W-1:0] rise_inc;
  logic [STEP_W-1:0] fall_dec;

  // Level times step size, clipped to the output range.
  function automatic logic [DUTY_W-1:0] duty_of(input logic [STEP_W-1:0] level);
    logic [PROD_W-1:0] p;
    p = PROD_W'(level) * STEP;
    return (p > PROD_W'(DUTY_SAT)) ? DUTY_SAT : p[DUTY_W-1:0];
  endfunction

  // Step logic for one sample.
  always_comb begin
    t         = $signed({sample[TEMP_W-1], sample});
    below_on  = t < thr.on_th;
    below_off = t < thr.off_th;
    above_off = t > thr.off_th;
    rise_inc  = rise_step + 3'd1;
    // The full-scale level drops by two at once, others by one, never below zero.
    if (fall_step == RAMP) begin
      fall_dec = (fall_step > 3'd1) ? fall_step - 3'd2 : 3'd0;
    end else begin
      fall_dec = (fall_step != 3'd0) ? fall_step - 3'd1 : 3'd0;
    end

    mode_next      = mode;
    rise_step_next = rise_step;
    fall_step_next = fall_step;
    duty_next      = duty;
    heat_next      = heat;

    unique case (mode)
      MODE_IDLE: begin
        if (below_on) begin
          heat_next      = 1'b1;
          mode_next      = MODE_RISE;
          rise_step_next = 3'd1;
          duty_next      = duty_of(3'd1);
        end
      end
      MODE_RISE: begin
        if (below_on) begin
          if (rise_step < RAMP) begin
            rise_step_next = rise_inc;
            duty_next      = duty_of(rise_inc);
          end else begin
            mode_next = MODE_HOLD;
          end
        end else if (below_off) begin
          mode_next = MODE_HOLD;
        end else if (above_off) begin
          fall_step_next = RAMP;
          mode_next      = MODE_FALL;
        end
      end
      MODE_HOLD: begin
        if (above_off) begin
          fall_step_next = RAMP;
          mode_next      = MODE_FALL;
        end
      end
      MODE_FALL: begin
        fall_step_next = fall_dec;
        if (fall_dec == 3'd0) begin
          heat_next      = 1'b0;
          duty_next      = '0;
          mode_next      = MODE_IDLE;
          rise_step_next = 3'd0;
        end else begin
          duty_next = duty_of(fall_step);
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // State advances once per sample that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      rise_step <= '0;
      fall_step <= FALL_RST;
      duty      <= '0;
      heat      <= 1'b0;
    end else if (adv) begin
      mode      <= mode_next;
      rise_step <= rise_step_next;
      fall_step <= fall_step_next;
      duty      <= duty_next;
      heat      <= heat_next;
    end
  end

  assign res.duty = duty_next;
  assign res.heat = heat_next;
  assign res.mode = mode_code(mode_next);

`ifndef ASSERT_OFF
  // Outside a heating sequence the duty is zero and the block is idle.
  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    !heat |-> (duty == '0) && (mode == MODE_IDLE))
    else $error("heater off but duty or mode not cleared");

  // Idle always carries the heater flag low.
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> !heat)
    else $error("idle with heater flag set");

  // Ramp up keeps its level within one to the ramp length.
  a_rise_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RISE) |-> (rise_step != 3'd0) && (rise_step <= RAMP))
    else $error("ramp-up level out of range");

  // Ramp down never sits at level zero.
  a_fall_live: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_FALL) |-> (fall_step != 3'd0))
    else $error("ramp-down reached level zero without leaving");

  // Without a sample moving on, the sequencer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(mode) && $stable(duty) && $stable(heat))
    else $error("state changed without a sample");
`endif

endmodule

// ===== rtl/heater_ramp_hysteresis_controller.sv =====
// Top level of the heater ramp controller with hysteresis thresholds.
// Depends on hrhc_pkg, hrhc_cfg and hrhc_ctrl.
//
//   channel   direction  beat carries
//   s_*       in         temperature sample, 1/16 degree C
//   m_*       out        duty, heater flag, mode after the sample
//   cfg_*     in         register index and write data
//
// An accepted sample passes the input register and then the result register on its way
// to its result beat; one sample per cycle is sustained while the result side does not stall.
// An input register and a result register part the two streams.
// Reset (rst, synchronous) clears the mode to idle and loads default settings.
// A stalled result holds the sequencer; the input register fills and then stalls.
module heater_ramp_hysteresis_controller
  import hrhc_pkg::*;
#(
  parameter int RAMP_STEPS = 4,
  parameter int DUTY_STEP  = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // temp_sample[12:0], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // duty_value[9:0], heater_flag, mode_now[1:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                     in_valid;
  logic signed [TEMP_W-1:0] in_sample;
  logic                     out_valid;
  result_t                  out_res;
  logic                     adv;
  thresh_t                  thr;
  result_t                  res;

  hrhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  hrhc_ctrl #(
    .RAMP_STEPS (RAMP_STEPS),
    .DUTY_STEP  (DUTY_STEP)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .sample (in_sample),
    .thr    (thr),
    .res    (res)
  );

  // A sample moves on when the result register is empty or being drained.
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= $signed(s_tdata[TEMP_W-1:0]);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.mode, out_res.heat, out_res.duty};

endmodule

// ===== tb/heater_ramp_hysteresis_controller_tb.sv =====
// Self-checking testbench for the heater ramp controller with hysteresis thresholds.
// Drives temperature beats and set-point writes, predicts every result beat and checks it.
// Depends on hrhc_pkg and heater_ramp_hysteresis_controller.
module heater_ramp_hysteresis_controller_tb;
  import hrhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RAMP     = 4;
  localparam int DUTY_INC   = 128;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 300;

  // Duty, heater flag and mode predictor with a queue of outstanding results.
  class duty_scoreboard;
    logic [TARGET_W-1:0] target;
    logic [BAND_W-1:0]   band;
    logic [MODE_W-1:0]   mode;
    logic [STEP_W-1:0]   rise_lvl;
    logic [STEP_W-1:0]   fall_lvl;
    logic [DUTY_W-1:0]   duty;
    logic                heat;
    result_t             due_q[$];
    int                  errors;

    function new();
      target   = TARGET_RST;
      band     = BAND_RST;
      mode     = CODE_IDLE;
      rise_lvl = '0;
      fall_lvl = FALL_RST;
      duty     = '0;
      heat     = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
      case (idx)
        REG_TARGET: target = val[TARGET_W-1:0];
        REG_BAND:   band = val[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    function int on_level();
      return (int'(target) - int'(band)) * 16;
    endfunction

    function int off_level();
      return (int'(target) + int'(band)) * 16;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function logic [DUTY_W-1:0] level_duty(logic [STEP_W-1:0] lvl);
      int d;
      d = int'(lvl) * DUTY_INC;
      return (d > int'(DUTY_SAT)) ? DUTY_SAT : d[DUTY_W-1:0];
    endfunction

    function logic [STEP_W-1:0] step_down(logic [STEP_W-1:0] lvl);
      return (lvl == 0) ? lvl : lvl - 1'b1;
    endfunction

    // Advance the mirrored state by one accepted sample and queue the result.
    function void note_sample(logic [TEMP_W-1:0] raw);
      int      t;
      int      on_th;
      int      off_th;
      result_t r;
      t      = int'($signed(raw));
      on_th  = on_level();
      off_th = off_level();
      case (mode)
        CODE_IDLE: begin
          if (t < on_th) begin
            heat     = 1'b1;
            mode     = CODE_RISE;
            rise_lvl = 3'd1;
            duty     = level_duty(rise_lvl);
          end
        end
        CODE_RISE: begin
          if (t < on_th) begin
            if (rise_lvl < N_RAMP) begin
              rise_lvl = rise_lvl + 1'b1;
              duty     = level_duty(rise_lvl);
            end else begin
              mode = CODE_HOLD;
            end
          end else if (t < off_th) begin
            mode = CODE_HOLD;
          end else if (t > off_th) begin
            fall_lvl = STEP_W'(N_RAMP);
            mode     = CODE_FALL;
          end
        end
        CODE_HOLD: begin
          if (t > off_th) begin
            fall_lvl = STEP_W'(N_RAMP);
            mode     = CODE_FALL;
          end
        end
        default: begin
          // The top level drops by two, later ones by one; zero returns to idle.
          duty = level_duty(fall_lvl);
          if (fall_lvl == N_RAMP) fall_lvl = step_down(fall_lvl);
          fall_lvl = step_down(fall_lvl);
          if (fall_lvl == 0) begin
            heat     = 1'b0;
            duty     = '0;
            mode     = CODE_IDLE;
            rise_lvl = '0;
          end
        end
      endcase
      r.duty = duty;
      r.heat = heat;
      r.mode = mode;
      due_q.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 100) $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare one result beat with the oldest outstanding expectation.
    task check_result(logic [15:0] beat);
      result_t want;
      if (due_q.size() == 0) begin
        report("result beat with nothing outstanding", beat, 16'd0);
        return;
      end
      want = due_q.pop_front();
      if (beat[9:0] !== want.duty)
        report("duty_value", 16'(beat[9:0]), 16'(want.duty));
      if (beat[10] !== want.heat)
        report("heater_flag", 16'(beat[10]), 16'(want.heat));
      if (beat[12:11] !== want.mode)
        report("mode_now", 16'(beat[12:11]), 16'(want.mode));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;     // temp_sample[12:0], zero pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;          // duty_value[9:0], heater_flag, mode_now[1:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  duty_scoreboard sb = new();
  int samples_in  = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  bit pressure_done = 1'b0;

  heater_ramp_hysteresis_controller uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Both sides run without gaps over one long stretch of the run.
  function automatic bit calm_window();
    return samples_in >= 900 && samples_in < 1100;
  endfunction

  // Record accepted beats on the sample and result channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata[TEMP_W-1:0]);
        samples_in <= samples_in + 1;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!pressure_done && samples_in >= 500) begin
      hold_left     = HOLD_OFF;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (calm_window()) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 23);
    end
  end

  // Offer one sample beat, with random gaps ahead of it, and wait for acceptance.
  task automatic send_sample(input int v);
    while (!calm_window() && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, v[TEMP_W-1:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain every outstanding result, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_setpoints(input int tgt, input int bnd);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TARGET;
    cfg_data  <= CFG_DATA_W'(tgt);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_TARGET, tgt);
    cfg_index <= REG_BAND;
    cfg_data  <= CFG_DATA_W'(bnd);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_BAND, bnd);
    cfg_valid <= 1'b0;
  endtask

  // Walk every mode: exact thresholds, full ramp to plateau, both ramp-down entries.
  task automatic run_directed();
    int on_th;
    int off_th;
    int seq[$];
    on_th  = sb.on_level();
    off_th = sb.off_level();
    seq = '{4095, on_th, on_th - 1, -4096, on_th - 1, on_th - 1, on_th - 1, off_th,
            on_th - 1, off_th + 1, 4095, -4096, 0, on_th - 1, on_th, off_th + 1, 0, 0, 0,
            on_th - 1, off_th, off_th + 1, 0, 0, 0};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Runs of samples in one temperature region, with some noise over the full range.
  task automatic run_random(input int count);
    int on_th;
    int off_th;
    int region;
    int run_len;
    int v;
    on_th  = sb.on_level();
    off_th = sb.off_level();
    while (count > 0) begin
      region  = $urandom_range(9);
      run_len = ($urandom_range(99) < 40) ? $urandom_range(6, 1) : 1;
      for (int k = 0; k < run_len && count > 0; k++) begin
        case (region)
          0, 1, 2: v = on_th - int'($urandom_range(48, 1));
          3, 4:    v = on_th + int'($urandom_range(off_th - on_th));
          5, 6:    v = off_th + int'($urandom_range(48, 1));
          7:       v = on_th;
          8:       v = off_th;
          default: v = int'($urandom_range(8191)) - 4096;
        endcase
        if (v < -4096) v = -4096;
        if (v > 4095) v = 4095;
        send_sample(v);
        count--;
      end
    end
  endtask

  initial begin
    int tgt_set[8] = '{10, 30, 0, 31, 0, 31, -1, -1};
    int bnd_set[8] = '{1, 10, 15, 0, 0, 15, -1, -1};
    int tgt;
    int bnd;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset set-points first, then extreme and random ones.
    run_directed();
    run_random(150);
    for (int p = 0; p < 8; p++) begin
      tgt = (tgt_set[p] < 0) ? $urandom_range(30, 10) : tgt_set[p];
      bnd = (bnd_set[p] < 0) ? $urandom_range(10, 1) : bnd_set[p];
      settle();
      load_setpoints(tgt, bnd);
      run_random(147);
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hrhc_pkg.sv
rtl/hrhc_cfg.sv
rtl/hrhc_ctrl.sv
rtl/heater_ramp_hysteresis_controller.sv
tb/heater_ramp_hysteresis_controller_tb.sv
